// ===== design/sbpf_pkg.sv =====
// ----------------------------------------------------------------------------
// sbpf_pkg: shared types and constants of the servo bus packet framer
// Command codes, protocol byte values and the packet handed to the serializer.
// ----------------------------------------------------------------------------
package sbpf_pkg;

    typedef enum logic [1:0] {
        OP_WRITE_BYTE = 2'd0,
        OP_WRITE_WORD = 2'd1,
        OP_READ_WORD  = 2'd2
    } t_op;

    localparam logic [7:0] HDR_BYTE   = 8'hFF;
    localparam logic [7:0] OPC_WRITE  = 8'h03;
    localparam logic [7:0] OPC_READ   = 8'h02;
    localparam logic [7:0] LEN_SHORT  = 8'd4;
    localparam logic [7:0] LEN_LONG   = 8'd5;
    localparam logic [7:0] READ_COUNT = 8'd2;

    localparam int PKT_BYTES = 9;
    localparam int CNT_W     = $clog2(PKT_BYTES + 1);

    localparam logic [CNT_W-1:0] CNT_SHORT = CNT_W'(PKT_BYTES - 1);
    localparam logic [CNT_W-1:0] CNT_LONG  = CNT_W'(PKT_BYTES);

    // One framed packet, byte 0 goes out first
    typedef struct packed {
        logic [PKT_BYTES-1:0][7:0] bytes;
        logic [CNT_W-1:0]          count;
    } t_packet;

endpackage

// ===== design/sbpf_serializer.sv =====
// ----------------------------------------------------------------------------
// sbpf_serializer: packet to byte stream
// Holds one framed packet and shifts it out one byte per cycle through an output
// register unless stalled; takes the next packet on the cycle the last byte leaves.
// ----------------------------------------------------------------------------
module sbpf_serializer
    import sbpf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_pkt_valid,
    input  t_packet i_pkt,
    output logic    o_pkt_ready,
    output logic    m_axis_tvalid,
    input  logic    m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] tx_byte
    output logic    m_axis_tlast
);

    logic [PKT_BYTES-1:0][7:0] r_data;
    logic [CNT_W-1:0]          r_left;
    logic                      r_out_valid;
    logic [7:0]                r_out_byte;
    logic                      r_out_last;

    logic out_ok;
    logic emit;
    logic finishing;
    logic load;

    assign out_ok      = !r_out_valid || m_axis_tready;
    assign emit        = out_ok && (r_left != '0);
    assign finishing   = emit && (r_left == CNT_W'(1));
    assign o_pkt_ready = (r_left == '0) || finishing;
    assign load        = i_pkt_valid && o_pkt_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_left <= i_pkt.count;
            end else if (emit) begin
                r_left <= r_left - CNT_W'(1);
            end
            if (out_ok) begin
                r_out_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= i_pkt.bytes;
        end else if (emit) begin
            r_data <= r_data >> 8;
        end
        if (emit) begin
            r_out_byte <= r_data[0];
            r_out_last <= (r_left == CNT_W'(1));
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tlast  = r_out_last;

endmodule

// ===== design/servo_bus_packet_framer_unit.sv =====
// ----------------------------------------------------------------------------
// servo_bus_packet_framer_unit: servo bus instruction packet framer
// Turns one write-byte, write-word or read-word command into its packet
// FF FF id len inst addr params checksum, one byte per cycle unless stalled, last marked.
// A command passes the capture, decode and packet stages and the serializer before
// its first byte is valid. A byte write or read is 8 bytes, a word write 9, paced by the
// one-byte-per-cycle output port; commands queue in the 3-stage front end.
// Reset: synchronous active-low i_rst_n empties every stage; no other state.
// ----------------------------------------------------------------------------
module servo_bus_packet_framer_unit
    import sbpf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [7:0] servo_id, [15:8] reg_addr, [31:16] value
    input  logic [1:0]  s_axis_tuser,   // [1:0] operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] tx_byte
    output logic        m_axis_tlast    // checksum byte, end of packet
);

    // Stage 1: captured request. An unused operation code is accepted and
    // dropped here, so it never produces a byte.
    logic        r_s1_valid;
    t_op         r_s1_op;
    logic [7:0]  r_s1_id;
    logic [7:0]  r_s1_addr;
    logic [15:0] r_s1_value;

    // Stage 2: packet body and two partial sums of the checksum
    logic        r_s2_valid;
    logic        r_s2_word;
    logic [7:0]  r_s2_id;
    logic [7:0]  r_s2_len;
    logic [7:0]  r_s2_inst;
    logic [7:0]  r_s2_addr;
    logic [7:0]  r_s2_p0;
    logic [7:0]  r_s2_p1;
    logic [7:0]  r_s2_sum_a;
    logic [7:0]  r_s2_sum_b;

    // Stage 3: complete packet waiting for the serializer
    logic        r_s3_valid;
    t_packet     r_s3_pkt;

    logic        ser_ready;
    logic        s3_ready;
    logic        s2_ready;
    logic        s1_ready;
    logic        in_take;
    logic        op_legal;

    logic [7:0]  n_s2_len;
    logic [7:0]  n_s2_inst;
    logic [7:0]  n_s2_p0;
    logic        n_s2_word;
    logic [7:0]  cks;
    t_packet     n_s3_pkt;

    // Each stage moves when it is empty or the stage after it takes its data
    assign s3_ready      = !r_s3_valid || ser_ready;
    assign s2_ready      = !r_s2_valid || s3_ready;
    assign s1_ready      = !r_s1_valid || s2_ready;
    assign s_axis_tready = s1_ready;
    assign in_take       = s_axis_tvalid && s1_ready;

    assign op_legal = (s_axis_tuser == OP_WRITE_BYTE) || (s_axis_tuser == OP_WRITE_WORD)
                   || (s_axis_tuser == OP_READ_WORD);

    // ---- stage 1: capture ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= in_take && op_legal;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_op    <= t_op'(s_axis_tuser);
            r_s1_id    <= s_axis_tdata[7:0];
            r_s1_addr  <= s_axis_tdata[15:8];
            r_s1_value <= s_axis_tdata[31:16];
        end
    end

    // ---- stage 2: decode the command into length, instruction, params ----
    always_comb begin
        n_s2_word = 1'b0;
        n_s2_len  = LEN_SHORT;
        n_s2_inst = OPC_WRITE;
        n_s2_p0   = r_s1_value[7:0];
        unique case (r_s1_op)
            OP_WRITE_BYTE: begin
                n_s2_word = 1'b0;
            end
            OP_WRITE_WORD: begin
                n_s2_word = 1'b1;
                n_s2_len  = LEN_LONG;
            end
            OP_READ_WORD: begin
                n_s2_inst = OPC_READ;
                n_s2_p0   = READ_COUNT;
            end
            default: begin
                n_s2_word = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_ready) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_ready && r_s1_valid) begin
            r_s2_word  <= n_s2_word;
            r_s2_id    <= r_s1_id;
            r_s2_len   <= n_s2_len;
            r_s2_inst  <= n_s2_inst;
            r_s2_addr  <= r_s1_addr;
            r_s2_p0    <= n_s2_p0;
            r_s2_p1    <= r_s1_value[15:8];
            // Split the checksum sum in two halves to keep each stage shallow
            r_s2_sum_a <= r_s1_id + n_s2_len + n_s2_inst;
            r_s2_sum_b <= r_s1_addr + n_s2_p0 + (n_s2_word ? r_s1_value[15:8] : 8'h00);
        end
    end

    // ---- stage 3: finish the checksum and lay out the packet ----
    assign cks = ~(r_s2_sum_a + r_s2_sum_b);

    always_comb begin
        n_s3_pkt.bytes[0] = HDR_BYTE;
        n_s3_pkt.bytes[1] = HDR_BYTE;
        n_s3_pkt.bytes[2] = r_s2_id;
        n_s3_pkt.bytes[3] = r_s2_len;
        n_s3_pkt.bytes[4] = r_s2_inst;
        n_s3_pkt.bytes[5] = r_s2_addr;
        n_s3_pkt.bytes[6] = r_s2_p0;
        // A word write carries one more parameter, pushing the checksum back
        n_s3_pkt.bytes[7] = r_s2_word ? r_s2_p1 : cks;
        n_s3_pkt.bytes[8] = r_s2_word ? cks : 8'h00;
        n_s3_pkt.count    = r_s2_word ? CNT_LONG : CNT_SHORT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (s3_ready) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_ready && r_s2_valid) begin
            r_s3_pkt <= n_s3_pkt;
        end
    end

    // ---- byte serializer and output register ----
    sbpf_serializer u_ser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pkt_valid   (r_s3_valid),
        .i_pkt         (r_s3_pkt),
        .o_pkt_ready   (ser_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== design/sbpf_checker.sv =====
// ----------------------------------------------------------------------------
// sbpf_checker: port-level checks of the servo bus packet framer
// Tracks the byte position inside the outgoing packet and checks framing.
// ----------------------------------------------------------------------------
module sbpf_checker
    import sbpf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata,
    input  logic       m_axis_tlast
);

    logic             out_take;
    logic [CNT_W-1:0] r_pos;

    assign out_take = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (out_take) begin
            if (m_axis_tlast || (r_pos == CNT_W'(PKT_BYTES - 1))) begin
                r_pos <= '0;
            end else begin
                r_pos <= r_pos + CNT_W'(1);
            end
        end
    end

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output request changed while stalled");

    a_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_take && (r_pos < CNT_W'(2)) |-> (m_axis_tdata == HDR_BYTE))
        else $error("packet does not open with two header bytes");

    a_no_early_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_take && (r_pos < CNT_SHORT - CNT_W'(1)) |-> !m_axis_tlast)
        else $error("packet ended too early");

    a_last_in_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_take && (r_pos == CNT_LONG - CNT_W'(1)) |-> m_axis_tlast)
        else $error("packet longer than nine bytes");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind servo_bus_packet_framer_unit sbpf_checker u_sbpf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
